// File: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and codes for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;
  localparam int MAX_ORDER_DEF = 10;
  localparam int NUM_TOP_DEF   = 4;
  localparam int CELL_SHIFT_DEF = 12;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_COUNT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXHAUST = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic [4:0] TAG_USED = 5'd31;
  localparam logic [12:0] USED_MAX = 13'd8191;
endpackage

// File: sv/buddy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator with tag and link memories under one sequencer.
// ----------------------------------------------------------------------------
// One command at a time: start is taken while busy is low, and the result is
// shown with out_valid for exactly one cycle; the receiver cannot hold it off.
// The block first runs a clearing pass over all NUM_TOP << MAX_ORDER cells
// after reset (tag memory set to used, top blocks chained), busy high meanwhile.
// An allocate searches the orders upward from the request, pops the head of
// the order found, and splits it back down one order at a time. A free reads
// the buddy's tag at each merge step and unlinks the buddy, either from the
// head of its list or by walking the list and splicing it out, then pushes
// the merged block and reports. A count walks its list one entry at a time.
// Bad requests go straight from idle to the report. Every memory access goes
// through the single read port of the tag and link memories.
module buddy_block_allocator_unit #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
  parameter int NUM_TOP   = bba_pkg::NUM_TOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_order,
  input  logic [11:0] in_block_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_alloc_index,
  output logic [12:0] out_used_cells,
  output logic signed [4:0] out_largest_free_order,
  output logic [12:0] out_free_count
);
  localparam int NCELLS = NUM_TOP << MAX_ORDER;
  localparam int AW  = $clog2(NCELLS + 1);   // fits NONE
  localparam int IW  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int NORD = MAX_ORDER + 1;
  localparam int OW = $clog2(NORD + 1);
  localparam logic [AW-1:0] NONE = AW'(NCELLS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_A_SCAN, S_A_POP, S_A_POPW, S_A_SPLIT, S_A_DONE,
    S_F_RDTAG, S_F_TAGW, S_F_UNL, S_F_WALK, S_F_WALKW, S_F_SPLICE, S_F_PUSH,
    S_C_WALK, S_C_WALKW, S_OUT
  } state_t;

  state_t state_r;
  logic [4:0]    tag_mem  [NCELLS];
  logic [AW-1:0] link_mem [NCELLS];
  logic [AW-1:0] head_r [NORD];

  logic [IW-1:0] addr_r;
  logic [4:0]    tag_q;
  logic [AW-1:0] link_q;
  logic [OW-1:0] req_r, o_r;
  logic [AW-1:0] off_r, cur_r, tgt_r;
  logic [AW:0] steps_r;
  logic [12:0] used_r, fcnt_r;
  logic [1:0]  status_r;
  logic [11:0] alloc_r;

  // largest nonempty order, combinational over the small head register set
  logic signed [4:0] largest;
  always_comb begin
    largest = -5'sd1;
    for (int i = 0; i < NORD; i++) begin
      if (head_r[i] < NONE) largest = 5'(i);
    end
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      addr_r    <= '0;
      out_valid <= 1'b0;
      used_r    <= '0;
      for (int i = 0; i < NORD; i++) head_r[i] <= NONE;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLR: begin
          // clearing pass: top-block starts free and chained
          if (addr_r[MAX_ORDER-1:0] == '0 && MAX_ORDER > 0) begin
            tag_mem[addr_r]  <= 5'(MAX_ORDER);
            link_mem[addr_r] <= head_r[MAX_ORDER];
            head_r[MAX_ORDER] <= AW'(addr_r);
          end else begin
            tag_mem[addr_r] <= bba_pkg::TAG_USED;
          end
          if (AW'(addr_r) == NONE - 1) state_r <= S_IDLE;
          else addr_r <= addr_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            req_r    <= OW'(in_order);
            o_r      <= OW'(in_order);
            off_r    <= AW'(in_block_index);
            status_r <= bba_pkg::ST_OK;
            alloc_r  <= '0;
            fcnt_r   <= '0;
            steps_r  <= '0;
            if (in_func == bba_pkg::FUNC_ALLOC) begin
              if (32'(in_order) > MAX_ORDER) begin
                status_r <= bba_pkg::ST_BAD; state_r <= S_OUT;
              end else state_r <= S_A_SCAN;
            end else if (in_func == bba_pkg::FUNC_FREE) begin
              if (32'(in_order) > MAX_ORDER || 32'(in_block_index) >= NCELLS ||
                  (in_block_index & ((12'd1 << in_order) - 12'd1)) != '0) begin
                status_r <= bba_pkg::ST_BAD; state_r <= S_OUT;
              end else begin
                used_r <= (used_r > (13'd1 << in_order)) ?
                          used_r - (13'd1 << in_order) : '0;
                state_r <= S_F_RDTAG;
              end
            end else if (in_func == bba_pkg::FUNC_COUNT) begin
              if (32'(in_order) > MAX_ORDER) begin
                status_r <= bba_pkg::ST_BAD; state_r <= S_OUT;
              end else begin
                cur_r <= head_r[in_order]; state_r <= S_C_WALK;
              end
            end else state_r <= S_OUT;
          end
        end
        // allocate: search one order per cycle
        S_A_SCAN: begin
          if (32'(o_r) > MAX_ORDER) begin
            status_r <= bba_pkg::ST_EXHAUST; state_r <= S_OUT;
          end else if (head_r[o_r] < NONE) begin
            off_r  <= head_r[o_r];
            addr_r <= IW'(head_r[o_r]);
            state_r <= S_A_POP;
          end else o_r <= o_r + 1'b1;
        end
        S_A_POP: begin
          link_q  <= link_mem[addr_r];
          state_r <= S_A_POPW;
        end
        S_A_POPW: begin
          head_r[o_r] <= link_q;
          state_r <= S_A_SPLIT;
        end
        S_A_SPLIT: begin
          if (o_r > req_r) begin
            // push right half at order o-1
            tag_mem[IW'(off_r + (AW'(1) << (o_r - 1'b1)))]  <= 5'(o_r - 1'b1);
            link_mem[IW'(off_r + (AW'(1) << (o_r - 1'b1)))] <= head_r[o_r - 1'b1];
            head_r[o_r - 1'b1] <= off_r + (AW'(1) << (o_r - 1'b1));
            o_r <= o_r - 1'b1;
          end else state_r <= S_A_DONE;
        end
        S_A_DONE: begin
          tag_mem[IW'(off_r)] <= bba_pkg::TAG_USED;
          used_r  <= ({1'b0, used_r} + (14'd1 << req_r) > 14'(bba_pkg::USED_MAX)) ?
                     bba_pkg::USED_MAX : used_r + (13'd1 << req_r);
          alloc_r <= 12'(off_r);
          state_r <= S_OUT;
        end
        // free: check buddy tag
        S_F_RDTAG: begin
          if (32'(o_r) >= MAX_ORDER ||
              32'(off_r ^ (AW'(1) << o_r)) >= NCELLS) state_r <= S_F_PUSH;
          else begin
            tgt_r  <= off_r ^ (AW'(1) << o_r);
            tag_q  <= tag_mem[IW'(off_r ^ (AW'(1) << o_r))];
            state_r <= S_F_TAGW;
          end
        end
        S_F_TAGW: begin
          if (tag_q != 5'(o_r)) state_r <= S_F_PUSH;
          else begin
            cur_r   <= head_r[o_r];
            steps_r <= '0;
            state_r <= S_F_UNL;
          end
        end
        S_F_UNL: begin
          // unlink buddy, then advance one order
          if (cur_r >= NONE) begin
            // empty list: merge anyway
            if (tgt_r < off_r) off_r <= tgt_r;
            o_r <= o_r + 1'b1;
            state_r <= S_F_RDTAG;
          end else begin
            link_q <= link_mem[IW'(cur_r)];
            if (cur_r == tgt_r) steps_r <= '1;  // marks head removal
            state_r <= S_F_WALKW;
          end
        end
        S_F_WALKW: begin
          if (steps_r == '1) begin
            head_r[o_r] <= link_q;
            if (tgt_r < off_r) off_r <= tgt_r;
            o_r <= o_r + 1'b1; state_r <= S_F_RDTAG;
          end else if (link_q == tgt_r) begin
            addr_r  <= IW'(cur_r);
            state_r <= S_F_WALK;
          end else if (link_q >= NONE || 32'(steps_r) + 1 >= NCELLS) begin
            if (tgt_r < off_r) off_r <= tgt_r;
            o_r <= o_r + 1'b1; state_r <= S_F_RDTAG;
          end else begin
            cur_r   <= link_q;
            steps_r <= steps_r + 1'b1;
            link_q  <= link_mem[IW'(link_q)];
          end
        end
        S_F_WALK: begin
          // fetch buddy's next, spliced in next cycle
          link_q  <= link_mem[IW'(tgt_r)];
          state_r <= S_F_SPLICE;
        end
        S_F_SPLICE: begin
          link_mem[addr_r] <= link_q;
          if (tgt_r < off_r) off_r <= tgt_r;
          o_r <= o_r + 1'b1;
          state_r <= S_F_RDTAG;
        end
        S_F_PUSH: begin
          tag_mem[IW'(off_r)]  <= 5'(o_r);
          link_mem[IW'(off_r)] <= head_r[o_r];
          head_r[o_r] <= off_r;
          state_r <= S_OUT;
        end
        // count: walk one entry per pass through S_C_WALK and S_C_WALKW
        S_C_WALK: begin
          if (cur_r >= NONE || 32'(fcnt_r) >= NCELLS) state_r <= S_OUT;
          else begin
            fcnt_r <= fcnt_r + 1'b1;
            link_q <= link_mem[IW'(cur_r)];
            state_r <= S_C_WALKW;
          end
        end
        S_C_WALKW: begin
          cur_r <= link_q;
          state_r <= S_C_WALK;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_status <= status_r;
          out_alloc_index <= alloc_r;
          out_used_cells <= used_r;
          out_largest_free_order <= largest;
          out_free_count <= fcnt_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the buddy block allocator.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [1:0] out_status,
  input logic [11:0] out_alloc_index
);
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_busy_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer not taken");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bba_pkg::ST_BAD) else $error("bad status code");
  a_alloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bba_pkg::ST_OK) |-> out_alloc_index == '0)
    else $error("index on failed result");
endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status),
  .out_alloc_index(out_alloc_index)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy allocator testbench
// Drives allocate, free and count commands through the start/busy handshake
// and checks every strobed result against an in-bench buddy allocator model.
// ----------------------------------------------------------------------------

class alloc_scoreboard;
  localparam int MAXO = bba_pkg::MAX_ORDER_DEF;
  localparam int NC = bba_pkg::NUM_TOP_DEF << bba_pkg::MAX_ORDER_DEF;

  logic [4:0]  tag [NC];
  int          nxt [NC];
  int          head [MAXO+1];
  int          used;
  logic [1:0]  q_status [$];
  logic [11:0] q_alloc [$];
  logic [12:0] q_used [$];
  logic [4:0]  q_lfo [$];
  logic [12:0] q_cnt [$];
  int          errors;
  int          n_checked;

  function void reset_state();
    for (int i = 0; i < NC; i++) begin
      tag[i] = bba_pkg::TAG_USED;
      nxt[i] = 0;
    end
    for (int o = 0; o <= MAXO; o++) head[o] = NC;
    used = 0;
    for (int t = 0; t < bba_pkg::NUM_TOP_DEF; t++) push(MAXO, t << MAXO);
  endfunction

  function void push(int o, int off);
    nxt[off] = head[o];
    head[o] = off;
    tag[off] = o[4:0];
  endfunction

  function void unlink(int o, int target);
    int cur;
    int nx;
    cur = head[o];
    if (cur >= NC) return;
    if (cur == target) begin
      head[o] = nxt[cur];
      return;
    end
    for (int s = 0; s < NC && cur < NC; s++) begin
      nx = nxt[cur];
      if (nx == target) begin
        nxt[cur] = nxt[nx];
        return;
      end
      cur = nx;
    end
  endfunction

  // true when the tag marks this cell as the start of a free block
  function bit is_free_block(int off);
    return tag[off] != bba_pkg::TAG_USED;
  endfunction

  function void note_input(logic [1:0] fn, logic [3:0] ord, logic [11:0] idx);
    logic [1:0] st;
    int al, cnt, o, off, bud, lfo, cur;
    st = bba_pkg::ST_OK; al = 0; cnt = 0;
    if (fn == bba_pkg::FUNC_ALLOC) begin
      if (ord > MAXO) st = bba_pkg::ST_BAD;
      else begin
        o = ord;
        while (o <= MAXO && head[o] >= NC) o++;
        if (o > MAXO) st = bba_pkg::ST_EXHAUST;
        else begin
          off = head[o];
          head[o] = nxt[off];
          while (o > ord) begin
            o--;
            push(o, off + (1 << o));
          end
          tag[off] = bba_pkg::TAG_USED;
          used += 1 << ord;
          if (used > 8191) used = 8191;
          al = off;
        end
      end
    end else if (fn == bba_pkg::FUNC_FREE) begin
      if (ord > MAXO || idx >= NC || (idx & ((1 << ord) - 1)) != 0) st = bba_pkg::ST_BAD;
      else begin
        o = ord; off = idx;
        used = used > (1 << ord) ? used - (1 << ord) : 0;
        while (o < MAXO) begin
          bud = off ^ (1 << o);
          if (bud >= NC) break;
          if (tag[bud] != o) break;
          unlink(o, bud);
          if (bud < off) off = bud;
          o++;
        end
        push(o, off);
      end
    end else if (fn == bba_pkg::FUNC_COUNT) begin
      if (ord > MAXO) st = bba_pkg::ST_BAD;
      else begin
        cur = head[ord];
        while (cur < NC && cnt < NC) begin
          cnt++;
          cur = nxt[cur];
        end
      end
    end
    lfo = 31;
    for (int k = MAXO; k >= 0; k--) if (head[k] < NC && lfo == 31) lfo = k;
    q_status.push_back(st); q_alloc.push_back(al[11:0]); q_used.push_back(used[12:0]);
    q_lfo.push_back(lfo[4:0]); q_cnt.push_back(cnt[12:0]);
  endfunction

  function void check_result(logic [1:0] st, logic [11:0] al, logic [12:0] us,
                             logic [4:0] lf, logic [12:0] cn);
    logic [1:0] es; logic [11:0] ea; logic [12:0] eu; logic [4:0] el; logic [12:0] ec;
    if (q_status.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d", $time, st);
      errors++;
      return;
    end
    es = q_status.pop_front(); ea = q_alloc.pop_front(); eu = q_used.pop_front();
    el = q_lfo.pop_front(); ec = q_cnt.pop_front();
    n_checked++;
    if (st !== es) begin $display("%0t: status exp %0d act %0d", $time, es, st); errors++; end
    if (al !== ea) begin $display("%0t: alloc_index exp %0d act %0d", $time, ea, al); errors++; end
    if (us !== eu) begin $display("%0t: used_cells exp %0d act %0d", $time, eu, us); errors++; end
    if (lf !== el) begin $display("%0t: largest_free exp %0d act %0d", $time, el, lf); errors++; end
    if (cn !== ec) begin $display("%0t: free_count exp %0d act %0d", $time, ec, cn); errors++; end
  endfunction
endclass

module testbench;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WD_LIMIT = 200000;

  logic clk, rst_n, start, busy, out_valid;
  logic [1:0] in_func, out_status;
  logic [3:0] in_order;
  logic [11:0] in_block_index, out_alloc_index;
  logic [12:0] out_used_cells, out_free_count;
  logic signed [4:0] out_largest_free_order;

  alloc_scoreboard sb;
  int idle_cycles;
  int blk_off [$];
  int blk_ord [$];

  buddy_block_allocator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_order(in_order), .in_block_index(in_block_index),
    .out_valid(out_valid), .out_status(out_status), .out_alloc_index(out_alloc_index),
    .out_used_cells(out_used_cells), .out_largest_free_order(out_largest_free_order),
    .out_free_count(out_free_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_alloc_index, out_used_cells,
                      out_largest_free_order, out_free_count);
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog expired with no transfer", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // start stays high through a zero-length gap so it is driven once per edge
  task automatic gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return;
    start <= 0;
    repeat (r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk);
  endtask

  task automatic send(logic [1:0] fn, logic [3:0] ord, logic [11:0] idx);
    start <= 1; in_func <= fn; in_order <= ord; in_block_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(fn, ord, idx);
    // keep allocated-block bookkeeping for well-formed frees
    if (fn == bba_pkg::FUNC_ALLOC && sb.q_status[$] == bba_pkg::ST_OK) begin
      blk_off.push_back(int'(sb.q_alloc[$])); blk_ord.push_back(int'(ord));
    end
    gap();
  endtask

  task automatic free_random();
    int k;
    if (blk_off.size() == 0) begin
      send(bba_pkg::FUNC_FREE, 4'($urandom_range(0, 10)), 12'($urandom));
      return;
    end
    k = $urandom_range(0, blk_off.size() - 1);
    send(bba_pkg::FUNC_FREE, 4'(blk_ord[k]), 12'(blk_off[k]));
    blk_off.delete(k); blk_ord.delete(k);
  endtask

  initial begin
    int r;
    sb = new();
    sb.reset_state();
    rst_n = 0; start = 0; in_func = 0; in_order = 0; in_block_index = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, bad orders, bad frees, counts, unused code
    send(bba_pkg::FUNC_COUNT, 4'd10, 12'd0);
    send(bba_pkg::FUNC_COUNT, 4'd0, 12'd0);
    send(bba_pkg::FUNC_ALLOC, 4'd15, 12'd0);
    send(bba_pkg::FUNC_ALLOC, 4'd11, 12'd0);
    send(bba_pkg::FUNC_COUNT, 4'd15, 12'd0);
    send(bba_pkg::FUNC_ALLOC, 4'd0, 12'hfff);
    send(bba_pkg::FUNC_COUNT, 4'd9, 12'd0);
    send(bba_pkg::FUNC_FREE, 4'd4, 12'h003);
    send(bba_pkg::FUNC_FREE, 4'd12, 12'd0);
    send(FUNC_UNUSED, 4'hf, 12'hfff);
    send(bba_pkg::FUNC_FREE, 4'd0, 12'd0);
    blk_off.delete(); blk_ord.delete();
    // exhaust the arena, then free everything back
    for (int i = 0; i < 4; i++) send(bba_pkg::FUNC_ALLOC, 4'd10, 12'd0);
    send(bba_pkg::FUNC_ALLOC, 4'd0, 12'd0);
    send(bba_pkg::FUNC_COUNT, 4'd10, 12'd0);
    while (blk_off.size() > 0) free_random();
    send(bba_pkg::FUNC_ALLOC, 4'd0, 12'd0);
    send(bba_pkg::FUNC_ALLOC, 4'd0, 12'd0);
    send(bba_pkg::FUNC_FREE, 4'd0, 12'h001);
    send(bba_pkg::FUNC_FREE, 4'd0, 12'h001);  // double free goes unchecked
    blk_off.delete(); blk_ord.delete();
    send(bba_pkg::FUNC_FREE, 4'd0, 12'd0);
    send(bba_pkg::FUNC_COUNT, 4'd0, 12'd0);

    // random: mostly valid allocate/free pairs on small orders
    for (int n = 0; n < 450; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send(bba_pkg::FUNC_ALLOC,
                       4'($urandom_range(0, 9) < 8 ? $urandom_range(0, 4)
                                                   : $urandom_range(5, 10)),
                       12'd0);
      else if (r < 75) free_random();
      else if (r < 90) send(bba_pkg::FUNC_COUNT, 4'($urandom_range(0, 10)), 12'($urandom));
      else if (r < 95) send(bba_pkg::FUNC_ALLOC, 4'($urandom_range(0, 15)), 12'($urandom));
      else begin
        // noise: malformed free unless r is even and names a free block; else unused code
        r = $urandom_range(0, 4095);
        if (r >= 4096 || !sb.is_free_block(r & ~1) || (r & 1)) begin
          send(bba_pkg::FUNC_FREE, (r & 1) ? 4'($urandom_range(1, 15)) : 4'($urandom_range(11, 15)),
               12'(r | 1));
        end else send(FUNC_UNUSED, 4'($urandom), 12'($urandom));
      end
    end
    start <= 0;

    while (sb.q_status.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("checked %0d results over allocate, free, count, bad order and bad free cases",
             sb.n_checked);
    if (sb.errors == 0 && sb.q_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
